### rtl/ifd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_pkg
// Types and constants shared by the information frame deframer files.
// ----------------------------------------------------------------------------
package ifd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;

    // Register indexes, byte address = 4 * index.
    localparam logic [2:0] REG_FLAG_VALUE        = 3'd0;
    localparam logic [2:0] REG_ESCAPE_VALUE      = 3'd1;
    localparam logic [2:0] REG_FLAG_SUBSTITUTE   = 3'd2;
    localparam logic [2:0] REG_ESCAPE_SUBSTITUTE = 3'd3;
    localparam logic [2:0] REG_SENDER_ADDRESS    = 3'd4;
    localparam logic [2:0] REG_CONTROL_EVEN      = 3'd5;
    localparam logic [2:0] REG_CONTROL_ODD       = 3'd6;

    localparam logic [BYTE_W-1:0] RST_FLAG_VALUE        = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_VALUE      = 8'h7D;
    localparam logic [BYTE_W-1:0] RST_FLAG_SUBSTITUTE   = 8'h5E;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_SUBSTITUTE = 8'h5D;
    localparam logic [BYTE_W-1:0] RST_SENDER_ADDRESS    = 8'h03;
    localparam logic [BYTE_W-1:0] RST_CONTROL_EVEN      = 8'h00;
    localparam logic [BYTE_W-1:0] RST_CONTROL_ODD       = 8'h40;

    typedef enum logic [1:0] {
        EV_DATA     = 2'd0,
        EV_OK       = 2'd1,
        EV_MISMATCH = 2'd2,
        EV_BADESC   = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] flag_substitute;
        logic [BYTE_W-1:0] escape_substitute;
        logic [BYTE_W-1:0] sender_address;
        logic [BYTE_W-1:0] control_even;
        logic [BYTE_W-1:0] control_odd;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        event_kind_t       event_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_sequence;
    } result_t;

endpackage

### rtl/ifd_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_rx_if
// Valid/ready channel carrying raw received line bytes.
// ----------------------------------------------------------------------------
interface ifd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/ifd_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_evt_if
// Valid/ready channel carrying deframer events and payload bytes.
// ----------------------------------------------------------------------------
interface ifd_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic       frame_sequence;

    modport source (output valid, output event_kind, output payload_byte,
                    output frame_sequence, input ready);
    modport sink   (input valid, input event_kind, input payload_byte,
                    input frame_sequence, output ready);
endinterface

### rtl/info_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_deframer_unit
// Receives byte-stuffed information frames with XOR header and data checks
// and delivers payload bytes, end-of-frame status events and bad-escape events.
// ----------------------------------------------------------------------------
// A byte taken into the input register has its event, if any, formed by the
// frame core and registered in the result register when that can advance.
// Throughput: one byte per cycle; the frame state is updated in one pass. The
// line side stalls only while both registers are full and the event side waits.
// Reset: rst_n asynchronous, active low; the frame hunt restarts and all
// configuration registers return to their default values.
// ----------------------------------------------------------------------------
module info_frame_deframer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifd_pkg::PADDR_W-1:0]   paddr,
    input  logic [ifd_pkg::PDATA_W-1:0]   pwdata,
    output logic [ifd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    ifd_rx_if.sink                        rx,
    ifd_evt_if.source                     events
);
    import ifd_pkg::*;

    cfg_t              cfg_reg;
    logic [2:0]        reg_index;
    logic              cfg_write;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              step;
    result_t           result;

    logic              out_valid_reg;
    event_kind_t       out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_seq_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value        <= RST_FLAG_VALUE;
            cfg_reg.escape_value      <= RST_ESCAPE_VALUE;
            cfg_reg.flag_substitute   <= RST_FLAG_SUBSTITUTE;
            cfg_reg.escape_substitute <= RST_ESCAPE_SUBSTITUTE;
            cfg_reg.sender_address    <= RST_SENDER_ADDRESS;
            cfg_reg.control_even      <= RST_CONTROL_EVEN;
            cfg_reg.control_odd       <= RST_CONTROL_ODD;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_FLAG_VALUE:        cfg_reg.flag_value        <= pwdata[BYTE_W-1:0];
                REG_ESCAPE_VALUE:      cfg_reg.escape_value      <= pwdata[BYTE_W-1:0];
                REG_FLAG_SUBSTITUTE:   cfg_reg.flag_substitute   <= pwdata[BYTE_W-1:0];
                REG_ESCAPE_SUBSTITUTE: cfg_reg.escape_substitute <= pwdata[BYTE_W-1:0];
                REG_SENDER_ADDRESS:    cfg_reg.sender_address    <= pwdata[BYTE_W-1:0];
                REG_CONTROL_EVEN:      cfg_reg.control_even      <= pwdata[BYTE_W-1:0];
                REG_CONTROL_ODD:       cfg_reg.control_odd       <= pwdata[BYTE_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_FLAG_VALUE:        prdata[BYTE_W-1:0] = cfg_reg.flag_value;
            REG_ESCAPE_VALUE:      prdata[BYTE_W-1:0] = cfg_reg.escape_value;
            REG_FLAG_SUBSTITUTE:   prdata[BYTE_W-1:0] = cfg_reg.flag_substitute;
            REG_ESCAPE_SUBSTITUTE: prdata[BYTE_W-1:0] = cfg_reg.escape_substitute;
            REG_SENDER_ADDRESS:    prdata[BYTE_W-1:0] = cfg_reg.sender_address;
            REG_CONTROL_EVEN:      prdata[BYTE_W-1:0] = cfg_reg.control_even;
            REG_CONTROL_ODD:       prdata[BYTE_W-1:0] = cfg_reg.control_odd;
            default:               prdata = '0;
        endcase
    end

    // The held byte moves on whenever the result register is free or being
    // drained, so while that holds a new transaction can be taken every cycle.
    assign advance  = !out_valid_reg || events.ready;
    assign step     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    ifd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_kind_reg <= result.event_kind;
            out_byte_reg <= result.payload_byte;
            out_seq_reg  <= result.frame_sequence;
        end
    end

    assign events.valid          = out_valid_reg;
    assign events.event_kind     = 2'(out_kind_reg);
    assign events.payload_byte   = out_byte_reg;
    assign events.frame_sequence = out_seq_reg;

endmodule

### rtl/ifd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_core
// Frame state machine: header matching, destuffing, one-byte hold-back and
// XOR block check. Processes one byte per cycle when step is high.
// ----------------------------------------------------------------------------
module ifd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  ifd_pkg::cfg_t    cfg,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output ifd_pkg::result_t result
);
    import ifd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              seq_reg, seq_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] parity_reg, parity_next;

    always_comb
    begin
        logic              take;
        logic [BYTE_W-1:0] take_val;
        logic [BYTE_W-1:0] ctrl;

        phase_next      = phase_reg;
        seq_next        = seq_reg;
        esc_next        = esc_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        parity_next     = parity_reg;
        take            = 1'b0;
        take_val        = rx_byte;
        ctrl            = seq_reg ? cfg.control_odd : cfg.control_even;

        result.valid          = 1'b0;
        result.event_kind     = EV_DATA;
        result.payload_byte   = '0;
        result.frame_sequence = seq_reg;

        unique case (phase_reg)
            PH_FLAG:
            begin
                if (rx_byte == cfg.sender_address)
                    phase_next = PH_ADDR;
                else if (rx_byte != cfg.flag_value)
                    phase_next = PH_HUNT;
            end
            PH_ADDR:
            begin
                priority if (rx_byte == cfg.control_even)
                begin
                    seq_next   = 1'b0;
                    phase_next = PH_CTRL;
                end
                else if (rx_byte == cfg.control_odd)
                begin
                    seq_next   = 1'b1;
                    phase_next = PH_CTRL;
                end
                else if (rx_byte == cfg.flag_value)
                    phase_next = PH_FLAG;
                else
                    phase_next = PH_HUNT;
            end
            PH_CTRL:
            begin
                priority if (rx_byte == (cfg.sender_address ^ ctrl))
                begin
                    phase_next      = PH_DATA;
                    esc_next        = 1'b0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    parity_next     = '0;
                end
                else if (rx_byte == cfg.flag_value)
                    phase_next = PH_FLAG;
                else
                    phase_next = PH_HUNT;
            end
            PH_DATA:
            begin
                priority if (rx_byte == cfg.flag_value)
                begin
                    // A closing flag also opens the next frame.
                    result.valid = 1'b1;
                    if (esc_reg)
                        result.event_kind = EV_BADESC;
                    else if (held_valid_reg && held_reg == parity_reg)
                        result.event_kind = EV_OK;
                    else
                        result.event_kind = EV_MISMATCH;
                    esc_next   = 1'b0;
                    phase_next = PH_FLAG;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    priority if (rx_byte == cfg.flag_substitute)
                    begin
                        take     = 1'b1;
                        take_val = cfg.flag_value;
                    end
                    else if (rx_byte == cfg.escape_substitute)
                    begin
                        take     = 1'b1;
                        take_val = cfg.escape_value;
                    end
                    else
                    begin
                        result.valid      = 1'b1;
                        result.event_kind = EV_BADESC;
                        phase_next        = PH_HUNT;
                    end
                end
                else if (rx_byte == cfg.escape_value)
                    esc_next = 1'b1;
                else
                    take = 1'b1;
            end
            default:
                phase_next = (rx_byte == cfg.flag_value) ? PH_FLAG : PH_HUNT;
        endcase

        // The byte held back from an earlier step goes out only once a
        // later byte proves it is not the check byte.
        if (take)
        begin
            if (held_valid_reg)
            begin
                result.valid        = 1'b1;
                result.event_kind   = EV_DATA;
                result.payload_byte = held_reg;
                parity_next         = parity_reg ^ held_reg;
            end
            held_next       = take_val;
            held_valid_next = 1'b1;
        end

        if (!step)
            result.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            seq_reg        <= 1'b0;
            esc_reg        <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            parity_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            esc_reg        <= esc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            parity_reg     <= parity_next;
        end
    end

endmodule
